// File: rtl/tmi_pkg.sv
package tmi_pkg;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [15:0] pc;
        logic [7:0]  in_byte;
    } t_in_word;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        jump_taken;
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        halted;
        logic        loop_error;
    } t_out_word;

    localparam logic [7:0] CMD_RIGHT = 8'h3E;  // '>'
    localparam logic [7:0] CMD_LEFT  = 8'h3C;  // '<'
    localparam logic [7:0] CMD_INC   = 8'h2B;  // '+'
    localparam logic [7:0] CMD_DEC   = 8'h2D;  // '-'
    localparam logic [7:0] CMD_OUT   = 8'h2E;  // '.'
    localparam logic [7:0] CMD_IN    = 8'h2C;  // ','
    localparam logic [7:0] CMD_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CMD_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CMD_HALT  = 8'h21;  // '!'

    localparam logic [15:0] SKIP_MAX = 16'hFFFF;

endpackage

// File: rtl/tmi_tape.sv
module tmi_tape #(
    parameter int TAPE_SIZE = 32768,
    parameter int ADDR_W    = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    output logic              o_clr_busy
);

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(TAPE_SIZE - 1);

    logic [7:0]        mem [TAPE_SIZE];
    logic [7:0]        r_rd_data;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [7:0]        wd;

    // clearing sweep owns the write port until every cell is zero
    assign we = r_clr_busy | i_wr_en;
    assign wa = r_clr_busy ? r_clr_addr : i_wr_addr;
    assign wd = r_clr_busy ? 8'h00 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST_CELL) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

// File: rtl/tmi_stack.sv
module tmi_stack #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [15:0]      o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  logic [15:0]      i_wr_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/tape_machine_interpreter.sv
// Tape machine interpreter: executes one instruction of the nine-command
// tape language per input word.
// Input channel (i_in_valid / o_in_ready) carries the instruction byte, its
// program address and a byte for the read command. Output channel
// (o_out_valid / i_out_ready) returns one result word per input word, in
// order: next fetch address, loop jump flag, emitted byte, halt and error.
// A word accepted sits in the execute stage register; its result is then
// registered into the output register. Throughput: one word per cycle while
// the output is not stalled. The tape memory is read at the pointer as a word
// is accepted and written back as that word executes; a write to the cell
// being read is forwarded. The bracket stack memory does the same for its top entry.
// Reset: the pointer, stack count, skip depth and halt flag clear at once;
// the tape is then swept to zero one cell per cycle, with o_in_ready low
// throughout.
// Stall: a result waits in the output register while i_out_ready is low; one
// more word may be accepted into the execute stage and then o_in_ready
// drops until the output drains.
module tape_machine_interpreter #(
    parameter int TAPE_SIZE  = 32768,
    parameter int LOOP_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tmi_pkg::t_in_word    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tmi_pkg::t_out_word   o_out_data
);

    localparam int PTR_W  = (TAPE_SIZE > 1) ? $clog2(TAPE_SIZE) : 1;
    localparam int CNT_W  = $clog2(LOOP_DEPTH + 1);
    localparam int SIDX_W = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_CELL  = PTR_W'(TAPE_SIZE - 1);
    localparam logic [CNT_W-1:0] STACK_FULL = CNT_W'(LOOP_DEPTH);

    // execute stage
    logic                r_s1_valid;
    tmi_pkg::t_in_word   r_s1;
    logic [PTR_W-1:0]    r_ptr;
    logic [CNT_W-1:0]    r_cnt;
    logic [15:0]         r_skip;
    logic                r_halt;
    logic                r_tfwd_en;
    logic [7:0]          r_tfwd_data;
    logic                r_sfwd_en;
    logic [15:0]         r_sfwd_data;
    logic                r_out_valid;
    tmi_pkg::t_out_word  r_out;

    logic [PTR_W-1:0]    n_ptr;
    logic [CNT_W-1:0]    n_cnt;
    logic [15:0]         n_skip;
    logic                n_halt;
    tmi_pkg::t_out_word  res;

    logic                s1_fire;
    logic                in_acc;
    logic                clr_busy;
    logic [7:0]          tape_q;
    logic [15:0]         stack_q;
    logic [7:0]          cur_cell;
    logic [15:0]         tos;
    logic [15:0]         pc_inc;
    logic                t_we;
    logic [7:0]          t_wd;
    logic                s_we;
    logic [SIDX_W-1:0]   s_widx;
    logic [SIDX_W-1:0]   s_ridx;

    assign s1_fire    = r_s1_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~clr_busy & (~r_s1_valid | s1_fire);
    assign in_acc     = i_in_valid & o_in_ready;

    assign cur_cell = r_tfwd_en ? r_tfwd_data : tape_q;
    assign tos      = r_sfwd_en ? r_sfwd_data : stack_q;
    assign pc_inc   = r_s1.pc + 16'd1;
    assign s_widx   = SIDX_W'(r_cnt);

    always_comb begin
        n_ptr  = r_ptr;
        n_cnt  = r_cnt;
        n_skip = r_skip;
        n_halt = r_halt;
        t_we   = 1'b0;
        t_wd   = cur_cell;
        s_we   = 1'b0;
        res    = '{next_pc: pc_inc, jump_taken: 1'b0, out_byte: 8'h00,
                   out_valid: 1'b0, halted: r_halt, loop_error: 1'b0};
        if (s1_fire) begin
            if (r_halt) begin
                res.next_pc = r_s1.pc;
            end else if (r_skip != 16'd0) begin
                // only brackets count while skipping a loop body
                if (r_s1.cmd == tmi_pkg::CMD_OPEN) begin
                    if (r_skip != tmi_pkg::SKIP_MAX) begin
                        n_skip = r_skip + 16'd1;
                    end
                end else if (r_s1.cmd == tmi_pkg::CMD_CLOSE) begin
                    n_skip = r_skip - 16'd1;
                end
            end else begin
                unique case (r_s1.cmd)
                    tmi_pkg::CMD_RIGHT: begin
                        n_ptr = (r_ptr == LAST_CELL) ? '0 : r_ptr + 1'b1;
                    end
                    tmi_pkg::CMD_LEFT: begin
                        n_ptr = (r_ptr == '0) ? LAST_CELL : r_ptr - 1'b1;
                    end
                    tmi_pkg::CMD_INC: begin
                        t_we = 1'b1;
                        t_wd = cur_cell + 8'd1;
                    end
                    tmi_pkg::CMD_DEC: begin
                        t_we = 1'b1;
                        t_wd = cur_cell - 8'd1;
                    end
                    tmi_pkg::CMD_OUT: begin
                        res.out_byte  = cur_cell;
                        res.out_valid = 1'b1;
                    end
                    tmi_pkg::CMD_IN: begin
                        t_we = 1'b1;
                        t_wd = r_s1.in_byte;
                    end
                    tmi_pkg::CMD_OPEN: begin
                        if (cur_cell == 8'h00) begin
                            n_skip = 16'd1;
                        end else if (r_cnt >= STACK_FULL) begin
                            res.loop_error = 1'b1;
                        end else begin
                            s_we  = 1'b1;
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                    tmi_pkg::CMD_CLOSE: begin
                        if (r_cnt == '0) begin
                            res.loop_error = 1'b1;
                        end else if (cur_cell != 8'h00) begin
                            res.next_pc    = tos + 16'd1;
                            res.jump_taken = 1'b1;
                        end else begin
                            n_cnt = r_cnt - 1'b1;
                        end
                    end
                    tmi_pkg::CMD_HALT: begin
                        n_halt      = 1'b1;
                        res.next_pc = r_s1.pc;
                        res.halted  = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // top of stack after this cycle's push or pop
    assign s_ridx = (n_cnt == '0) ? '0 : SIDX_W'(n_cnt - 1'b1);

    tmi_tape #(
        .TAPE_SIZE (TAPE_SIZE),
        .ADDR_W    (PTR_W)
    ) u_tape (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_acc),
        .i_rd_addr  (n_ptr),
        .o_rd_data  (tape_q),
        .i_wr_en    (t_we),
        .i_wr_addr  (r_ptr),
        .i_wr_data  (t_wd),
        .o_clr_busy (clr_busy)
    );

    tmi_stack #(
        .DEPTH (LOOP_DEPTH),
        .IDX_W (SIDX_W)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_idx  (s_ridx),
        .o_rd_data (stack_q),
        .i_wr_en   (s_we),
        .i_wr_idx  (s_widx),
        .i_wr_data (r_s1.pc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_skip      <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
            r_tfwd_en   <= 1'b0;
            r_sfwd_en   <= 1'b0;
        end else begin
            r_ptr  <= n_ptr;
            r_cnt  <= n_cnt;
            r_skip <= n_skip;
            r_halt <= n_halt;
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                // the memories return the old word on a same-edge write: forward
                r_tfwd_en  <= t_we & (r_ptr == n_ptr);
                r_sfwd_en  <= s_we & (s_widx == s_ridx);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1        <= i_in_data;
            r_tfwd_data <= t_wd;
            r_sfwd_data <= r_s1.pc;
        end
        if (s1_fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: test/tape_machine_interpreter_checker.sv
`timescale 1ns / 100ps

module tape_machine_interpreter_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  tmi_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  tmi_pkg::t_out_word i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_jumps,
    output int                 o_loop_errors
);

    localparam int TAPE_CELLS  = 32768;
    localparam int STACK_SLOTS = 16;
    localparam int PRINT_CAP   = 100;

    logic [7:0]  tape_mem [TAPE_CELLS];
    logic [14:0] head;
    logic [15:0] open_addr [STACK_SLOTS];
    logic [4:0]  open_count;
    logic [15:0] skip_level;
    logic        halt_seen;

    tmi_pkg::t_out_word pending_results [$];
    int          fail_cnt;
    int          checked_cnt;
    int          jump_cnt;
    int          err_cnt;

    task automatic flag_mismatch(input string msg);
        if (fail_cnt < PRINT_CAP) begin
            $display("%0t ns  mismatch: %s", $time, msg);
        end
        fail_cnt++;
    endtask

    // One instruction against the local copy of the machine state
    task automatic exec_instr(input tmi_pkg::t_in_word w, output tmi_pkg::t_out_word r);
        r = '0;
        r.next_pc = w.pc + 16'd1;
        if (halt_seen) begin
            r.next_pc = w.pc;
        end else if (skip_level != 16'd0) begin
            // only brackets count while skipping a loop body
            if (w.cmd == tmi_pkg::CMD_OPEN) begin
                if (skip_level != tmi_pkg::SKIP_MAX) skip_level++;
            end else if (w.cmd == tmi_pkg::CMD_CLOSE) begin
                skip_level--;
            end
        end else begin
            case (w.cmd)
                tmi_pkg::CMD_RIGHT: head = head + 15'd1;
                tmi_pkg::CMD_LEFT:  head = head - 15'd1;
                tmi_pkg::CMD_INC:   tape_mem[head] = tape_mem[head] + 8'd1;
                tmi_pkg::CMD_DEC:   tape_mem[head] = tape_mem[head] - 8'd1;
                tmi_pkg::CMD_OUT: begin
                    r.out_byte  = tape_mem[head];
                    r.out_valid = 1'b1;
                end
                tmi_pkg::CMD_IN:    tape_mem[head] = w.in_byte;
                tmi_pkg::CMD_OPEN: begin
                    if (tape_mem[head] == 8'd0) begin
                        skip_level = 16'd1;
                    end else if (open_count >= STACK_SLOTS) begin
                        r.loop_error = 1'b1;
                    end else begin
                        open_addr[open_count[3:0]] = w.pc;
                        open_count++;
                    end
                end
                tmi_pkg::CMD_CLOSE: begin
                    if (open_count == 5'd0) begin
                        r.loop_error = 1'b1;
                    end else if (tape_mem[head] != 8'd0) begin
                        r.next_pc    = open_addr[4'(open_count - 5'd1)] + 16'd1;
                        r.jump_taken = 1'b1;
                    end else begin
                        open_count--;
                    end
                end
                tmi_pkg::CMD_HALT: begin
                    halt_seen = 1'b1;
                    r.next_pc = w.pc;
                end
                default: ;
            endcase
        end
        r.halted = halt_seen;
    endtask

    always @(posedge i_clk) begin
        tmi_pkg::t_out_word want;
        tmi_pkg::t_out_word got;
        if (!i_rst_n) begin
            foreach (tape_mem[i]) tape_mem[i] = 8'd0;
            head        = '0;
            open_count  = '0;
            skip_level  = '0;
            halt_seen   = 1'b0;
            fail_cnt    = 0;
            checked_cnt = 0;
            jump_cnt    = 0;
            err_cnt     = 0;
            pending_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                exec_instr(i_in_data, want);
                if (want.jump_taken) jump_cnt++;
                if (want.loop_error) err_cnt++;
                pending_results.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("result word with nothing outstanding (next_pc %h)",
                                            got.next_pc));
                end else begin
                    want = pending_results.pop_front();
                    if (got.next_pc !== want.next_pc)
                        flag_mismatch($sformatf("word %0d next_pc %h, want %h",
                                                checked_cnt, got.next_pc, want.next_pc));
                    if (got.jump_taken !== want.jump_taken)
                        flag_mismatch($sformatf("word %0d jump_taken %b, want %b",
                                                checked_cnt, got.jump_taken, want.jump_taken));
                    if (got.out_byte !== want.out_byte)
                        flag_mismatch($sformatf("word %0d out_byte %h, want %h",
                                                checked_cnt, got.out_byte, want.out_byte));
                    if (got.out_valid !== want.out_valid)
                        flag_mismatch($sformatf("word %0d out_valid %b, want %b",
                                                checked_cnt, got.out_valid, want.out_valid));
                    if (got.halted !== want.halted)
                        flag_mismatch($sformatf("word %0d halted %b, want %b",
                                                checked_cnt, got.halted, want.halted));
                    if (got.loop_error !== want.loop_error)
                        flag_mismatch($sformatf("word %0d loop_error %b, want %b",
                                                checked_cnt, got.loop_error, want.loop_error));
                    checked_cnt++;
                end
            end
        end
        o_fail_count  <= fail_cnt;
        o_pending     <= pending_results.size();
        o_checked     <= checked_cnt;
        o_jumps       <= jump_cnt;
        o_loop_errors <= err_cnt;
    end

endmodule

// File: test/tape_machine_interpreter_tb.sv
`timescale 1ns / 100ps

module tape_machine_interpreter_tb;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 5;
    localparam int STALL_LIMIT     = 100000;
    localparam int RANDOM_WORDS    = 420;
    localparam int STACK_SLOTS     = 16;
    localparam int HOLD_OFF_AT     = 150;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    tmi_pkg::t_in_word  in_data;
    logic        out_valid;
    logic        out_ready;
    tmi_pkg::t_out_word out_data;

    int          fail_count;
    int          pending;
    int          checked;
    int          jumps;
    int          bracket_errs;

    int          words_sent;
    int          words_taken;
    int          idle_cycles;
    int          send_run;
    int          recv_run;
    int          stop_at;
    logic [15:0] fetch_pc;

    tape_machine_interpreter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    tape_machine_interpreter_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_jumps       (jumps),
        .o_loop_errors (bracket_errs)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Idle cycles before the next word; occasionally a run of back-to-back words
    function automatic int draw_gap(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            run_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == tmi_pkg::CMD_HALT) b = 8'h00;
        return b;
    endfunction

    function automatic logic [7:0] body_op();
        case ($urandom_range(0, 6))
            0:       return tmi_pkg::CMD_RIGHT;
            1:       return tmi_pkg::CMD_LEFT;
            2:       return tmi_pkg::CMD_INC;
            3:       return tmi_pkg::CMD_DEC;
            4:       return tmi_pkg::CMD_OUT;
            5:       return tmi_pkg::CMD_IN;
            default: return noise_byte();
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [7:0] op, input logic [7:0] arg_byte);
        int gap;
        gap = draw_gap(send_run);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{cmd: op, pc: fetch_pc, in_byte: arg_byte};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
        fetch_pc = fetch_pc + 16'd1;
    endtask

    task automatic run_body();
        repeat ($urandom_range(0, 2)) send_word(body_op(), 8'($urandom_range(0, 255)));
    endtask

    // Nested loops; mostly entered on a nonzero cell and left on a zero one
    task automatic run_nest(input int depth);
        int k;
        for (k = 0; k < depth; k++) begin
            if ($urandom_range(0, 3) != 0)
                send_word(tmi_pkg::CMD_IN, 8'($urandom_range(1, 255)));
            send_word(tmi_pkg::CMD_OPEN, 8'($urandom_range(0, 255)));
            run_body();
        end
        for (k = 0; k < depth; k++) begin
            run_body();
            if ($urandom_range(0, 3) != 0) send_word(tmi_pkg::CMD_IN, 8'h00);
            send_word(tmi_pkg::CMD_CLOSE, 8'($urandom_range(0, 255)));
        end
    endtask

    // Open on a zero cell and skip a balanced body
    task automatic run_skip();
        int inner;
        int k;
        inner = $urandom_range(0, 3);
        send_word(tmi_pkg::CMD_IN, 8'h00);
        send_word(tmi_pkg::CMD_OPEN, 8'($urandom_range(0, 255)));
        for (k = 0; k < inner; k++) begin
            run_body();
            send_word(tmi_pkg::CMD_OPEN, 8'($urandom_range(0, 255)));
        end
        for (k = 0; k <= inner; k++) begin
            run_body();
            send_word(tmi_pkg::CMD_CLOSE, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_drain();
        send_word(tmi_pkg::CMD_IN, 8'h00);
        repeat ($urandom_range(1, STACK_SLOTS + 2))
            send_word(tmi_pkg::CMD_CLOSE, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_walk();
        repeat ($urandom_range(1, 8))
            send_word($urandom_range(0, 1) ? tmi_pkg::CMD_RIGHT : tmi_pkg::CMD_LEFT,
                      8'($urandom_range(0, 255)));
        send_word(tmi_pkg::CMD_IN, 8'($urandom_range(0, 255)));
        send_word(tmi_pkg::CMD_OUT, 8'($urandom_range(0, 255)));
    endtask

    initial begin : sink
        int gap;
        out_ready   = 1'b0;
        words_taken = 0;
        recv_run    = 0;
        @(posedge i_rst_n);
        forever begin
            // one long hold-off so the pipe fills and back-pressures the sender
            gap = (words_taken == HOLD_OFF_AT) ? HOLD_OFF_CYCLES : draw_gap(recv_run);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            @(negedge i_clk);
            words_taken++;
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        words_sent = 0;
        send_run   = 0;
        fetch_pc   = 16'hFFFE;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: close on empty stack, pointer wrap both ways, address wrap
        send_word(tmi_pkg::CMD_CLOSE, 8'hFF);
        send_word(tmi_pkg::CMD_LEFT,  8'h00);
        send_word(tmi_pkg::CMD_OUT,   8'hFF);
        send_word(tmi_pkg::CMD_DEC,   8'h00);
        send_word(tmi_pkg::CMD_OUT,   8'h00);
        send_word(tmi_pkg::CMD_INC,   8'hFF);
        send_word(tmi_pkg::CMD_RIGHT, 8'hFF);
        send_word(tmi_pkg::CMD_IN,    8'hFF);
        send_word(tmi_pkg::CMD_OUT,   8'h00);
        send_word(tmi_pkg::CMD_IN,    8'h00);
        // skip a nested body on a zero cell
        send_word(tmi_pkg::CMD_OPEN,  8'h00);
        send_word(tmi_pkg::CMD_OPEN,  8'h00);
        send_word(tmi_pkg::CMD_INC,   8'h00);
        send_word(tmi_pkg::CMD_CLOSE, 8'h00);
        send_word(tmi_pkg::CMD_OUT,   8'h00);
        send_word(tmi_pkg::CMD_CLOSE, 8'h00);
        // count a loop down: two repeats, then the pop
        send_word(tmi_pkg::CMD_IN,    8'h03);
        send_word(tmi_pkg::CMD_OPEN,  8'h00);
        send_word(tmi_pkg::CMD_DEC,   8'h00);
        send_word(tmi_pkg::CMD_CLOSE, 8'h00);
        send_word(tmi_pkg::CMD_DEC,   8'h00);
        send_word(tmi_pkg::CMD_CLOSE, 8'h00);
        send_word(tmi_pkg::CMD_DEC,   8'h00);
        send_word(tmi_pkg::CMD_CLOSE, 8'h00);
        send_word(8'h00,     8'h00);
        send_word(8'hFF,     8'hFF);

        // open one level past the stack, overflowing it if every level is entered
        run_nest(STACK_SLOTS + 1);
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) fetch_pc = 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 9))
                0:       send_word(noise_byte(), 8'($urandom_range(0, 255)));
                1, 2:    send_word(body_op(), 8'($urandom_range(0, 255)));
                7:       run_skip();
                8:       run_drain();
                9:       run_walk();
                default: run_nest($urandom_range(1, STACK_SLOTS + 2));
            endcase
        end

        // halt last: everything after it is ignored
        send_word(tmi_pkg::CMD_HALT, 8'($urandom_range(0, 255)));
        repeat (4) begin
            fetch_pc = 16'($urandom_range(0, 65535));
            send_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Issued %0d instruction words, %0d results compared.", words_sent, checked);
        $display("Covered %0d backward jumps, %0d bracket errors and a %0d-cycle output stall.",
                 jumps, bracket_errs, HOLD_OFF_CYCLES);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/tmi_pkg.sv
rtl/tmi_tape.sv
rtl/tmi_stack.sv
rtl/tape_machine_interpreter.sv
test/tape_machine_interpreter_checker.sv
test/tape_machine_interpreter_tb.sv
